@@ rtl/gmm_pkg.sv @@
// gmm_pkg: shared types and constants of the group median/mean combiner.
// Holds the controller/datapath command and status structs and register codes.
// No dependencies.
`default_nettype none

package gmm_pkg;

    localparam int THRESH_W = 32;
    localparam int MIN_W    = 7;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_METHOD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GOOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

    localparam logic                       METHOD_RESET = 1'b0;
    localparam logic [MIN_W-1:0]           MIN_RESET    = '0;
    localparam logic signed [THRESH_W-1:0] THRESH_RESET = -32'sd655360000;

    localparam logic METHOD_MEDIAN = 1'b0;
    localparam logic METHOD_MEAN   = 1'b1;

    typedef struct packed {
        logic ingest;
        logic load_missing;
        logic med_step;
        logic div_start;
        logic div_step;
        logic div_fix;
        logic clear;
    } gmm_cmd_t;

    typedef struct packed {
        logic last;
        logic missing;
        logic mean_sel;
        logic med_last;
        logic div_last;
    } gmm_status_t;

endpackage

`default_nettype wire

@@ rtl/gmm_chain.sv @@
// gmm_chain: sorted insertion chain of good scores, ascending from slot 0.
// Inserts one score per cycle; in drain mode shifts toward slot 0 one per cycle.
// No package dependencies.
`default_nettype none

module gmm_chain #(
    parameter int MAX_GROUP  = 64,
    parameter int SCORE_BITS = 32,
    parameter int CNT_W      = 7
) (
    input  wire logic                         clk,
    input  wire logic                         insert,
    input  wire logic                         shift,
    input  wire logic signed [SCORE_BITS-1:0] value,
    input  wire logic [CNT_W-1:0]             count,
    output logic signed [SCORE_BITS-1:0]      head
);

    logic signed [SCORE_BITS-1:0] slot_reg  [MAX_GROUP];
    logic signed [SCORE_BITS-1:0] slot_next [MAX_GROUP];
    logic [MAX_GROUP-1:0]         gt;

    genvar i;
    generate
        for (i = 0; i < MAX_GROUP; i++)
        begin : g_slot
            localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
            logic signed [SCORE_BITS-1:0] up_val;
            logic signed [SCORE_BITS-1:0] dn_val;

            // empty slots act as +infinity
            assign gt[i] = (IDX >= count) || (slot_reg[i] > value);

            if (i == MAX_GROUP - 1)
            begin : g_top
                assign up_val = slot_reg[i];
            end
            else
            begin : g_mid
                assign up_val = slot_reg[i+1];
            end

            if (i == 0)
            begin : g_first
                assign dn_val = value;
            end
            else
            begin : g_rest
                assign dn_val = gt[i-1] ? slot_reg[i-1] : value;
            end

            always_comb
            begin
                if (shift)
                begin
                    slot_next[i] = up_val;
                end
                else if (insert && gt[i])
                begin
                    slot_next[i] = dn_val;
                end
                else
                begin
                    slot_next[i] = slot_reg[i];
                end
            end

            always_ff @(posedge clk)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
    endgenerate

    assign head = slot_reg[0];

endmodule

`default_nettype wire

@@ rtl/gmm_div.sv @@
// gmm_div: restoring unsigned divider, one quotient bit per step.
// Divides the sum magnitude by the good count. No package dependencies.
`default_nettype none

module gmm_div #(
    parameter int SUM_W = 38,
    parameter int CNT_W = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             step,
    input  wire logic [SUM_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic [SUM_W-1:0]      quotient,
    output logic                  last
);

    localparam int IT_W = $clog2(SUM_W);

    logic [SUM_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [IT_W-1:0]  iter_reg, iter_next;
    logic [CNT_W:0]   rem_sh;
    logic [CNT_W:0]   rem_sub;
    logic             ge;

    assign rem_sh  = {rem_reg, q_reg[SUM_W-1]};
    assign ge      = rem_sh >= {1'b0, divisor};
    assign rem_sub = rem_sh - {1'b0, divisor};

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        iter_next = iter_reg;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            iter_next = '0;
        end
        else if (step)
        begin
            q_next    = {q_reg[SUM_W-2:0], ge};
            rem_next  = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            iter_next = iter_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
        end
        else
        begin
            iter_reg <= iter_next;
        end
    end

    assign quotient = q_reg;
    assign last     = (iter_reg == IT_W'(SUM_W - 1));

endmodule

`default_nettype wire

@@ rtl/gmm_dpath.sv @@
// gmm_dpath: config registers, group counters, sum, result register.
// Uses gmm_pkg, gmm_chain (median) and gmm_div (mean).
`default_nettype none

module gmm_dpath
    import gmm_pkg::*;
#(
    parameter int MAX_GROUP  = 64,
    parameter int SCORE_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]             cfg_data,
    input  wire logic signed [SCORE_BITS-1:0] score,
    input  wire logic                         last_in_group,
    input  wire gmm_cmd_t                     cmd,
    output gmm_status_t                       status,
    output logic signed [SCORE_BITS-1:0]      combined_score,
    output logic                              is_missing,
    output logic                              overflowed
);

    localparam int CNT_W = $clog2(MAX_GROUP + 1);
    localparam int SUM_W = SCORE_BITS + $clog2(MAX_GROUP);
    localparam int CMP_W = (SCORE_BITS > THRESH_W) ? SCORE_BITS : THRESH_W;
    localparam int MW    = (CNT_W > MIN_W) ? CNT_W : MIN_W;

    logic                       method_reg;
    logic [MIN_W-1:0]           min_reg;
    logic signed [THRESH_W-1:0] thresh_reg;

    logic [CNT_W-1:0]              count_reg, count_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic                          ovf_reg, ovf_next;
    logic [CNT_W-1:0]              m_reg, m_next;
    logic signed [SCORE_BITS-1:0]  lo_reg;
    logic signed [SCORE_BITS-1:0]  res_reg, res_next;

    logic signed [CMP_W-1:0]      score_ext, thresh_ext;
    logic                         good, room, insert;
    logic signed [SCORE_BITS-1:0] head;
    logic [CNT_W-1:0]             half;
    logic signed [SCORE_BITS:0]   mid_sum;
    logic [SUM_W-1:0]             sum_mag;
    logic [SUM_W-1:0]             quotient;
    logic [SCORE_BITS-1:0]        q_trunc;
    logic                         missing;
    logic                         div_last;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg <= METHOD_RESET;
            min_reg    <= MIN_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_METHOD:    method_reg <= cfg_data[0];
                REG_MIN_GOOD:  min_reg    <= cfg_data[MIN_W-1:0];
                REG_THRESHOLD: thresh_reg <= cfg_data[THRESH_W-1:0];
                default:       ;
            endcase
        end
    end

    assign score_ext  = CMP_W'(score);
    assign thresh_ext = CMP_W'(thresh_reg);
    assign good       = score_ext > thresh_ext;
    assign room       = count_reg < CNT_W'(MAX_GROUP);
    assign insert     = cmd.ingest && good && room;

    assign missing = (count_reg == '0) ||
                     ((min_reg != '0) && (MW'(count_reg) < MW'(min_reg)));

    assign half    = count_reg >> 1;
    assign mid_sum = (SCORE_BITS + 1)'(lo_reg) + (SCORE_BITS + 1)'(head);
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign q_trunc = quotient[SCORE_BITS-1:0];

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        m_next     = m_reg;
        res_next   = res_reg;
        if (cmd.clear)
        begin
            count_next = '0;
            sum_next   = '0;
            ovf_next   = 1'b0;
            m_next     = '0;
        end
        else if (insert)
        begin
            count_next = count_reg + 1'b1;
            sum_next   = sum_reg + SUM_W'(score);
        end
        else if (cmd.ingest && good)
        begin
            ovf_next = 1'b1;
        end

        if (cmd.med_step)
        begin
            m_next = m_reg + 1'b1;
            if (count_reg[0])
            begin
                res_next = head;
            end
            else
            begin
                // floor of half the two middle scores
                res_next = mid_sum[SCORE_BITS:1];
            end
        end
        else if (cmd.load_missing)
        begin
            res_next = SCORE_BITS'(thresh_ext);
        end
        else if (cmd.div_fix)
        begin
            res_next = sum_reg[SUM_W-1] ? -$signed(q_trunc) : $signed(q_trunc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            m_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
            m_reg     <= m_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd.med_step && (m_reg + 1'b1 == half))
        begin
            lo_reg <= head;
        end
    end

    gmm_chain #(
        .MAX_GROUP  (MAX_GROUP),
        .SCORE_BITS (SCORE_BITS),
        .CNT_W      (CNT_W)
    ) u_chain (
        .clk    (clk),
        .insert (insert),
        .shift  (cmd.med_step),
        .value  (score),
        .count  (count_reg),
        .head   (head)
    );

    gmm_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .step     (cmd.div_step),
        .dividend (sum_mag),
        .divisor  (count_reg),
        .quotient (quotient),
        .last     (div_last)
    );

    assign status.last     = last_in_group;
    assign status.missing  = missing;
    assign status.mean_sel = (method_reg == METHOD_MEAN);
    assign status.med_last = (m_reg == half);
    assign status.div_last = div_last;

    assign combined_score = res_reg;
    assign is_missing     = missing;
    assign overflowed     = ovf_reg;

endmodule

`default_nettype wire

@@ rtl/gmm_ctrl.sv @@
// gmm_ctrl: group sequencer for the combiner.
// Drives gmm_dpath through gmm_cmd_t; uses gmm_pkg.
`default_nettype none

module gmm_ctrl
    import gmm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    input  wire gmm_status_t status,
    output gmm_cmd_t         cmd
);

    localparam logic [2:0] ST_COLLECT = 3'd0;
    localparam logic [2:0] ST_EVAL    = 3'd1;
    localparam logic [2:0] ST_MEDIAN  = 3'd2;
    localparam logic [2:0] ST_DIV     = 3'd3;
    localparam logic [2:0] ST_SIGN    = 3'd4;
    localparam logic [2:0] ST_OUT     = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            ST_COLLECT:
            begin
                in_stall   = 1'b0;
                cmd.ingest = in_valid;
                if (in_valid && status.last)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.missing)
                begin
                    cmd.load_missing = 1'b1;
                    state_next       = ST_OUT;
                end
                else if (status.mean_sel)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_MEDIAN;
                end
            end
            ST_MEDIAN:
            begin
                cmd.med_step = 1'b1;
                if (status.med_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                cmd.div_fix = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request accepted while result pending");

    a_last_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && status.last) |=> (state_reg == ST_EVAL))
        else $error("group end not evaluated");

    a_sign_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIGN) |=> out_valid)
        else $error("mean result not presented");

    a_missing_direct: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL && status.missing) |=> (out_valid && $stable(status.missing)))
        else $error("missing result path broken");

endmodule

`default_nettype wire

@@ rtl/group_median_or_mean_skip_missing_top.sv @@
// group_median_or_mean_skip_missing_top: median or mean of the good scores of a group.
// Uses gmm_pkg, gmm_ctrl and gmm_dpath.
//
// Channel  Handshake            Payload
// in       in_valid / in_stall  score, last_in_group
// out      out_valid / out_stall combined_score, is_missing, overflowed
// cfg      cfg_write_en         cfg_index, cfg_data
//
// One score per cycle into the sorted insertion chain while a group is open.
// After the last score: eval, then median shifts of the chain or mean divider steps and
// a sign fix (a missing group loads the threshold instead), then the result is held.
// Input is stalled from group end until the result request is taken.
// Async active-low reset clears counters and the sequencer and resets the config.
`default_nettype none

module group_median_or_mean_skip_missing_top
    import gmm_pkg::*;
#(
    parameter int MAX_GROUP  = 64,
    parameter int SCORE_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]             cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [SCORE_BITS-1:0] score,
    input  wire logic                         last_in_group,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [SCORE_BITS-1:0]      combined_score,
    output logic                              is_missing,
    output logic                              overflowed
);

    gmm_cmd_t    cmd;
    gmm_status_t status;

    gmm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    gmm_dpath #(
        .MAX_GROUP  (MAX_GROUP),
        .SCORE_BITS (SCORE_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .score          (score),
        .last_in_group  (last_in_group),
        .cmd            (cmd),
        .status         (status),
        .combined_score (combined_score),
        .is_missing     (is_missing),
        .overflowed     (overflowed)
    );

endmodule

`default_nettype wire

@@ tb/sv/gmm_result_checker.sv @@
`timescale 1ns / 1ps
// gmm_result_checker: watches the config, request and result channels of the group
// median/mean combiner, predicts every group result and compares it field by field.
// Depends on gmm_pkg for register codes, widths and reset values.
module gmm_result_checker
    import gmm_pkg::*;
#(
    parameter int MAX_GROUP  = 64,
    parameter int SCORE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic signed [SCORE_BITS-1:0] score,
    input  logic                         last_in_group,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic signed [SCORE_BITS-1:0] combined_score,
    input  logic                         is_missing,
    input  logic                         overflowed,
    output int                           error_count,
    output int                           results_pending
);

    typedef struct {
        logic signed [SCORE_BITS-1:0] value;
        logic                         missing;
        logic                         dropped;
    } group_result_t;

    group_result_t              expected_groups[$];
    logic                       method;
    logic [MIN_W-1:0]           min_good;
    logic signed [THRESH_W-1:0] threshold;
    longint                     kept_scores[MAX_GROUP];
    int                         kept_count;
    longint                     kept_sum;
    logic                       dropped_any;
    int                         mismatch_total;

    function automatic group_result_t combine_group();
        longint        sorted[MAX_GROUP];
        longint        v;
        longint        value;
        int            j;
        group_result_t r;
        r.missing = (kept_count == 0) || (min_good != 0 && kept_count < int'(min_good));
        r.dropped = dropped_any;
        if (r.missing)
            value = longint'(threshold);
        else if (method == METHOD_MEAN)
            value = kept_sum / longint'(kept_count);
        else
        begin
            for (int i = 0; i < kept_count; i++)
            begin
                v = kept_scores[i];
                j = i;
                while (j > 0 && sorted[j-1] > v)
                begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = v;
            end
            if (kept_count % 2 == 1)
                value = sorted[kept_count/2];
            else
                value = (sorted[kept_count/2] + sorted[kept_count/2 - 1]) >>> 1;  // floor
        end
        r.value = value[SCORE_BITS-1:0];
        return r;
    endfunction

    task automatic flag_error(input string msg);
        mismatch_total++;
        if (mismatch_total <= 10)
            $display("%0t gmm mismatch: %s", $time, msg);
    endtask

    task automatic take_score(input logic signed [SCORE_BITS-1:0] s, input logic is_last);
        if (longint'(s) > longint'(threshold))
        begin
            if (kept_count < MAX_GROUP)
            begin
                kept_scores[kept_count] = longint'(s);
                kept_count++;
                kept_sum += longint'(s);
            end
            else
                dropped_any = 1'b1;
        end
        if (is_last)
        begin
            expected_groups.push_back(combine_group());
            kept_count  = 0;
            kept_sum    = 0;
            dropped_any = 1'b0;
        end
    endtask

    task automatic check_result();
        group_result_t want;
        if (expected_groups.size() == 0)
        begin
            flag_error($sformatf("unexpected result score %0d missing %0b overflow %0b",
                                 combined_score, is_missing, overflowed));
            return;
        end
        want = expected_groups.pop_front();
        if (combined_score !== want.value || is_missing !== want.missing ||
            overflowed !== want.dropped)
            flag_error($sformatf("expected score %0d missing %0b overflow %0b, got %0d %0b %0b",
                                 want.value, want.missing, want.dropped,
                                 combined_score, is_missing, overflowed));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method          = METHOD_RESET;
            min_good        = MIN_RESET;
            threshold       = THRESH_RESET;
            kept_count      = 0;
            kept_sum        = 0;
            dropped_any     = 1'b0;
            mismatch_total  = 0;
            expected_groups.delete();
            error_count     <= 0;
            results_pending <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_METHOD:    method    = cfg_data[0];
                    REG_MIN_GOOD:  min_good  = cfg_data[MIN_W-1:0];
                    REG_THRESHOLD: threshold = cfg_data[THRESH_W-1:0];
                    default:       ;
                endcase
            end
            if (in_valid && !in_stall)
                take_score(score, last_in_group);
            if (out_valid && !out_stall)
                check_result();
            error_count     <= mismatch_total;
            results_pending <= expected_groups.size();
        end
    end

endmodule

@@ tb/sv/group_median_or_mean_skip_missing_top_test.sv @@
`timescale 1ns / 1ps
// group_median_or_mean_skip_missing_top_test: drives directed and random score groups
// through the combiner under several register settings and idle patterns.
// Depends on gmm_pkg, gmm_result_checker and the combiner RTL.
module group_median_or_mean_skip_missing_top_test;
    import gmm_pkg::*;

    localparam int MAX_GROUP      = 64;
    localparam int SCORE_BITS     = 32;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 200;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [CFG_IDX_W-1:0]         REG_UNUSED = 2'd3;
    localparam logic signed [SCORE_BITS-1:0] SCORE_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [SCORE_BITS-1:0] SCORE_MIN  = 32'sh8000_0000;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_W-1:0]             cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic signed [SCORE_BITS-1:0] score = '0;
    logic                         last_in_group = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [SCORE_BITS-1:0] combined_score;
    logic                         is_missing;
    logic                         overflowed;

    int     error_count;
    int     results_pending;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_requests = 0;
    int     hold_seen = 0;
    int     hold_left = 0;
    int     quiet_cycles = 0;
    int     items_sent = 0;
    longint cur_threshold = longint'(THRESH_RESET);

    group_median_or_mean_skip_missing_top #(
        .MAX_GROUP  (MAX_GROUP),
        .SCORE_BITS (SCORE_BITS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .score          (score),
        .last_in_group  (last_in_group),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .combined_score (combined_score),
        .is_missing     (is_missing),
        .overflowed     (overflowed)
    );

    gmm_result_checker #(
        .MAX_GROUP  (MAX_GROUP),
        .SCORE_BITS (SCORE_BITS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .score           (score),
        .last_in_group   (last_in_group),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .combined_score  (combined_score),
        .is_missing      (is_missing),
        .overflowed      (overflowed),
        .error_count     (error_count),
        .results_pending (results_pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // result side: random stall, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_requests != hold_seen)
        begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic signed [SCORE_BITS-1:0] s, input logic is_last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        score         <= s;
        last_in_group <= is_last;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
    endtask

    task automatic configure(input logic m, input int min_cnt, input longint thr);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_METHOD;
        cfg_data     <= ($urandom() & ~32'h1) | CFG_W'(m);
        @(posedge clk);
        cfg_index    <= REG_MIN_GOOD;
        cfg_data     <= ($urandom() & ~32'h7F) | CFG_W'(min_cnt);
        @(posedge clk);
        cfg_index    <= REG_THRESHOLD;
        cfg_data     <= thr[CFG_W-1:0];
        @(posedge clk);
        cfg_index    <= REG_UNUSED;
        cfg_data     <= $urandom();
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cur_threshold = thr;
    endtask

    function automatic logic signed [SCORE_BITS-1:0] pick_score(input int miss_pct);
        longint v;
        int     sel;
        if ($urandom_range(99) < miss_pct)
            v = $urandom_range(1) ? cur_threshold
                                  : cur_threshold - longint'($urandom_range(1000000));
        else
        begin
            sel = $urandom_range(9);
            if (sel == 0)
                v = longint'(SCORE_MAX);
            else if (sel == 1)
                v = cur_threshold + 1;
            else if (sel < 5)
                v = cur_threshold + longint'($urandom_range(1 << 20));
            else
                v = longint'(int'($urandom()));
        end
        if (v > longint'(SCORE_MAX))
            v = longint'(SCORE_MAX);
        if (v < longint'(SCORE_MIN))
            v = longint'(SCORE_MIN);
        return v[SCORE_BITS-1:0];
    endfunction

    task automatic send_random_group();
        int n;
        int miss_pct;
        int i;
        if ($urandom_range(99) < 8)
        begin
            n        = $urandom_range(60, 140);
            miss_pct = 10;
        end
        else
        begin
            n        = $urandom_range(1, 8);
            miss_pct = 25;
        end
        for (i = 0; i < n; i++)
            send_item(pick_score(miss_pct), i == n - 1);
    endtask

    initial
    begin
        int     phase_end;
        logic   m;
        int     min_cnt;
        longint thr;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // median at reset settings: extremes, threshold edge, even/odd counts
        send_item(SCORE_MAX, 1'b1);
        send_item(SCORE_MIN, 1'b1);
        send_item(THRESH_RESET, 1'b1);
        send_item(THRESH_RESET + 1, 1'b1);
        send_item(-1, 1'b0);
        send_item(-2, 1'b1);
        send_item(SCORE_MAX, 1'b0);
        send_item(SCORE_MAX - 1, 1'b1);
        send_item(5, 1'b0);
        send_item(-7, 1'b0);
        send_item(3, 1'b1);
        send_item(SCORE_MIN, 1'b0);
        send_item(4, 1'b0);
        send_item(10, 1'b0);
        send_item(-2, 1'b0);
        send_item(SCORE_MIN, 1'b1);

        // mean truncation and minimum count
        configure(METHOD_MEAN, 0, longint'(THRESH_RESET));
        send_item(-3, 1'b0);
        send_item(0, 1'b1);
        send_item(SCORE_MAX, 1'b0);
        send_item(SCORE_MAX, 1'b1);
        configure(METHOD_MEAN, 3, longint'(THRESH_RESET));
        send_item(1, 1'b0);
        send_item(2, 1'b1);
        send_item(1, 1'b0);
        send_item(2, 1'b0);
        send_item(3, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin m = METHOD_MEDIAN; min_cnt = 0;   thr = longint'(THRESH_RESET); end
                1: begin m = METHOD_MEAN;   min_cnt = 0;   thr = longint'(SCORE_MIN);    end
                2: begin m = METHOD_MEDIAN; min_cnt = 64;  thr = 0;                      end
                3: begin m = METHOD_MEAN;   min_cnt = 3;   thr = longint'(int'($urandom())) >>> 4; end
                4: begin m = METHOD_MEDIAN; min_cnt = 127; thr = longint'(SCORE_MAX);    end
                5: begin m = METHOD_MEDIAN; min_cnt = 1;   thr = longint'(SCORE_MIN);    end
                6: begin m = METHOD_MEAN;   min_cnt = 64;  thr = longint'(THRESH_RESET); end
                default: begin m = METHOD_MEDIAN; min_cnt = 0; thr = longint'(int'($urandom())); end
            endcase
            configure(m, min_cnt, thr);
            send_idle_pct  = (p % 4 == 1) ? 51 : (p % 4 == 3) ? 38 : 0;
            recv_stall_pct <= (p % 4 == 2) ? 51 : (p % 4 == 3) ? 38 : 0;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                send_random_group();
                if (p == 4 && hold_requests == 0)
                    hold_requests <= hold_requests + 1;
                if (p == 3 && items_sent >= phase_end - PHASE_ITEMS / 2 && send_idle_pct != 0)
                begin
                    wait_drained();
                    send_idle_pct = 0;
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
